FILE: sv/grbe_pkg.sv
`default_nettype none

package grbe_pkg;

   // fixed port widths
   localparam int unsigned WORD_BITS  = 64;
   localparam int unsigned PIVOT_BITS = 6;
   localparam int unsigned RANK_BITS  = 7;
   localparam int unsigned COORD_BITS = 7;

   localparam logic [RANK_BITS-1:0]  RANK_MAX    = 7'd64;
   localparam logic [COORD_BITS-1:0] COORD_RESET = 7'd64;

   // operation codes
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REDUCE = 1'b1;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_PIVOT
   } state_type;

endpackage

`default_nettype wire

FILE: sv/grbe_cell.sv
`default_nettype none

module grbe_cell #(
   parameter int unsigned VECTOR_BITS = 64
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   prev_tok,
   input  wire logic [VECTOR_BITS-1:0] prev_acc,
   input  wire logic                   vec_bit,
   output      logic                   next_tok,
   output      logic [VECTOR_BITS-1:0] next_acc,
   input  wire logic                   upd_en,
   input  wire logic [VECTOR_BITS-1:0] upd_row,
   input  wire logic [VECTOR_BITS-1:0] upd_pbit,
   input  wire logic                   pivot_here,
   output      logic                   row_valid
);

   logic                   valid_ff, valid_in;
   logic [VECTOR_BITS-1:0] row_ff, row_in;
   logic                   tok_ff;
   logic [VECTOR_BITS-1:0] acc_ff, acc_in;

   // partial residual: fold in this row when its pivot bit is set in the vector
   always_comb begin
      acc_in = acc_ff;
      if (prev_tok) begin
         acc_in = prev_acc ^ ((valid_ff && vec_bit) ? row_ff : '0);
      end
   end

   // elimination and write-back of a new row
   always_comb begin
      row_in   = row_ff;
      valid_in = valid_ff;
      if (upd_en) begin
         if (pivot_here) begin
            row_in   = upd_row;
            valid_in = 1'b1;
         end else if (valid_ff && (|(row_ff & upd_pbit))) begin
            row_in = row_ff ^ upd_row;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         tok_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         tok_ff   <= prev_tok;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      row_ff <= row_in;
      acc_ff <= acc_in;
   end

   assign next_tok  = tok_ff;
   assign next_acc  = acc_ff;
   assign row_valid = valid_ff;

endmodule

`default_nettype wire

FILE: sv/gf2_reduced_basis_engine.sv
// channel | ports                                   | direction
// --------+-----------------------------------------+----------
// req     | req_valid/req_stall, operation, vector  | in
// rsp     | rsp_valid/rsp_stall, five result fields | out
// csr     | csr_write, csr_coordinates_in_use       | in
//
// An item walks the residual word along the row of cells, is masked into the
// residual register, then has its pivot found and the basis written back.
// The input reopens only after write-back, so one item is in work at a time.
// Synchronous active-high reset empties the basis and sets the coordinate
// count to 64. A stalled result holds in the output register; the next word
// is accepted meanwhile and waits only at write-back.
`default_nettype none

module gf2_reduced_basis_engine
   import grbe_pkg::*;
#(
   parameter int unsigned VECTOR_BITS = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_valid,
   output      logic                  req_stall,
   input  wire logic                  req_operation,
   input  wire logic [WORD_BITS-1:0]  req_vector,
   // response channel
   output      logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   output      logic                  rsp_inserted,
   output      logic                  rsp_in_span,
   output      logic [WORD_BITS-1:0]  rsp_residual,
   output      logic [PIVOT_BITS-1:0] rsp_pivot_col,
   output      logic [RANK_BITS-1:0]  rsp_basis_rank,
   // configuration
   input  wire logic                  csr_write,
   input  wire logic [COORD_BITS-1:0] csr_coordinates_in_use
);

   localparam int unsigned IDX_BITS = (VECTOR_BITS > 1) ? $clog2(VECTOR_BITS) : 1;

   state_type state_ff, state_in;

   logic [COORD_BITS-1:0]  coords_ff;
   logic [VECTOR_BITS-1:0] mask;
   logic [VECTOR_BITS-1:0] mask_ff;
   logic [VECTOR_BITS-1:0] vec_ff;
   logic                   op_ff;
   logic                   start_ff;
   logic [VECTOR_BITS-1:0] res_ff;
   logic [RANK_BITS-1:0]   rank_ff, rank_in;

   logic                   accept;
   logic                   finish;
   logic                   do_insert;
   logic [VECTOR_BITS-1:0] pbit;
   logic [IDX_BITS-1:0]    pidx;
   logic [VECTOR_BITS-1:0] valid_vec;
   logic                   pivot_taken;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_inserted_ff;
   logic                   rsp_in_span_ff;
   logic [WORD_BITS-1:0]   rsp_residual_ff;
   logic [PIVOT_BITS-1:0]  rsp_pivot_col_ff;
   logic [RANK_BITS-1:0]   rsp_basis_rank_ff;

   logic                   tok_chain [VECTOR_BITS+1];
   logic [VECTOR_BITS-1:0] acc_chain [VECTOR_BITS+1];

   // coordinate mask, count of zero acts as one
   for (genvar i = 0; i < VECTOR_BITS; i++) begin : g_mask
      assign mask[i] = (i == 0) || (coords_ff > COORD_BITS'(i));
   end

   // row of cells, one per pivot column
   assign tok_chain[0] = start_ff;
   assign acc_chain[0] = vec_ff;

   for (genvar i = 0; i < VECTOR_BITS; i++) begin : g_cell
      grbe_cell #(
         .VECTOR_BITS(VECTOR_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .prev_tok  (tok_chain[i]),
         .prev_acc  (acc_chain[i]),
         .vec_bit   (vec_ff[i]),
         .next_tok  (tok_chain[i+1]),
         .next_acc  (acc_chain[i+1]),
         .upd_en    (do_insert),
         .upd_row   (res_ff),
         .upd_pbit  (pbit),
         .pivot_here(pbit[i]),
         .row_valid (valid_vec[i])
      );
   end

   // lowest set bit of the residual, one-hot, then its index
   assign pbit = res_ff & (~res_ff + VECTOR_BITS'(1));

   always_comb begin
      pidx = '0;
      for (int i = 0; i < VECTOR_BITS; i++) begin
         if (pbit[i]) begin
            pidx = pidx | IDX_BITS'(i);
         end
      end
   end

   assign pivot_taken = |(valid_vec & pbit);

   // sequencer: next state and handshake
   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      finish    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = reset;
            if (req_valid) begin
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            if (tok_chain[VECTOR_BITS]) begin
               state_in = ST_PIVOT;
            end
         end
         ST_PIVOT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               finish   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign accept    = req_valid && !req_stall;
   assign do_insert = finish && (op_ff == OP_INSERT) && (|res_ff);

   // rank after this word
   always_comb begin
      rank_in = rank_ff;
      if (do_insert && !pivot_taken && (rank_ff < RANK_MAX)) begin
         rank_in = rank_ff + RANK_BITS'(1);
      end
   end

   // output register handshake
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         coords_ff    <= COORD_RESET;
         start_ff     <= 1'b0;
         rank_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            coords_ff <= csr_coordinates_in_use;
         end
         start_ff     <= accept;
         rank_ff      <= rank_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // word capture and final residual
   always_ff @(posedge clock) begin
      if (accept) begin
         vec_ff  <= req_vector[VECTOR_BITS-1:0] & mask;
         mask_ff <= mask;
         op_ff   <= req_operation;
      end
      if ((state_ff == ST_SWEEP) && tok_chain[VECTOR_BITS]) begin
         res_ff <= acc_chain[VECTOR_BITS] & mask_ff;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_inserted_ff   <= do_insert;
         rsp_in_span_ff    <= ~(|res_ff);
         rsp_residual_ff   <= WORD_BITS'(res_ff);
         rsp_pivot_col_ff  <= do_insert ? PIVOT_BITS'(pidx) : '0;
         rsp_basis_rank_ff <= rank_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_inserted   = rsp_inserted_ff;
   assign rsp_in_span    = rsp_in_span_ff;
   assign rsp_residual   = rsp_residual_ff;
   assign rsp_pivot_col  = rsp_pivot_col_ff;
   assign rsp_basis_rank = rsp_basis_rank_ff;

endmodule

`default_nettype wire

FILE: sv/grbe_checker.sv
`default_nettype none

module grbe_checker
   import grbe_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_stall,
   input wire logic                  rsp_inserted,
   input wire logic                  rsp_in_span,
   input wire logic [WORD_BITS-1:0]  rsp_residual,
   input wire logic [PIVOT_BITS-1:0] rsp_pivot_col,
   input wire logic [RANK_BITS-1:0]  rsp_basis_rank
);

   // a stalled result word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_residual))
      else $error("stalled result changed");

   // span flag matches an all-zero residual
   a_span: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_in_span == (rsp_residual == '0)))
      else $error("span flag disagrees with residual");

   // pivot reads zero when nothing was added
   a_pivot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_inserted |-> (rsp_pivot_col == '0))
      else $error("pivot nonzero without insert");

   // pivot of an added row is a set bit of the residual
   a_pivot_bit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_inserted |-> !rsp_in_span && rsp_residual[rsp_pivot_col])
      else $error("pivot not a set residual bit");

   // rank never exceeds the word width
   a_rank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_basis_rank <= RANK_MAX))
      else $error("rank out of range");

endmodule

bind gf2_reduced_basis_engine grbe_checker u_grbe_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_inserted  (rsp_inserted),
   .rsp_in_span   (rsp_in_span),
   .rsp_residual  (rsp_residual),
   .rsp_pivot_col (rsp_pivot_col),
   .rsp_basis_rank(rsp_basis_rank)
);

`default_nettype wire

FILE: dv/tb.sv
module tb
   import grbe_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned COORD_LIMIT  = WORD_BITS;
   localparam int unsigned HOLD_CYCLES  = 400;
   localparam int unsigned SEGMENT_SIZE = 110;

   typedef struct {
      logic                  inserted;
      logic                  in_span;
      logic [WORD_BITS-1:0]  residual;
      logic [PIVOT_BITS-1:0] pivot_col;
      logic [RANK_BITS-1:0]  basis_rank;
   } basis_outcome_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic                  req_operation;
   logic [WORD_BITS-1:0]  req_vector;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic                  rsp_inserted;
   logic                  rsp_in_span;
   logic [WORD_BITS-1:0]  rsp_residual;
   logic [PIVOT_BITS-1:0] rsp_pivot_col;
   logic [RANK_BITS-1:0]  rsp_basis_rank;
   logic                  csr_write;
   logic [COORD_BITS-1:0] csr_coordinates_in_use;

   // predicted basis and register copy
   logic [WORD_BITS-1:0]  basis_copy [WORD_BITS];
   logic [WORD_BITS-1:0]  pivot_copy;
   int unsigned           rank_copy;
   logic [COORD_BITS-1:0] coords_copy;

   basis_outcome_type pending_outcomes [$];
   int unsigned       fail_count;
   int unsigned       send_idle_pct;
   int unsigned       recv_idle_pct;
   int unsigned       backlog_ask;

   gf2_reduced_basis_engine #(
      .VECTOR_BITS(COORD_LIMIT)
   ) dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_operation          (req_operation),
      .req_vector             (req_vector),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_inserted           (rsp_inserted),
      .rsp_in_span            (rsp_in_span),
      .rsp_residual           (rsp_residual),
      .rsp_pivot_col          (rsp_pivot_col),
      .rsp_basis_rank         (rsp_basis_rank),
      .csr_write              (csr_write),
      .csr_coordinates_in_use (csr_coordinates_in_use)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // reduce one word against the predicted basis and insert the residual
   function automatic basis_outcome_type apply_word(input logic op,
                                                    input logic [WORD_BITS-1:0] vec);
      basis_outcome_type     outcome;
      int unsigned           width;
      logic [WORD_BITS-1:0]  mask;
      logic [WORD_BITS-1:0]  masked;
      logic [WORD_BITS-1:0]  leftover;
      int unsigned           col;
      int                    i;
      width = coords_copy;
      if (width < 1) width = 1;
      if (width > COORD_LIMIT) width = COORD_LIMIT;
      mask = (width >= WORD_BITS) ? '1 : ((64'd1 << width) - 64'd1);
      masked = vec & mask;
      leftover = masked;
      for (i = 0; i < WORD_BITS; i++) begin
         if (pivot_copy[i] && masked[i]) leftover ^= basis_copy[i];
      end
      leftover &= mask;
      outcome.inserted  = 1'b0;
      outcome.pivot_col = '0;
      // new row: lowest set bit is the pivot, clear it from every other row
      if (op == OP_INSERT && leftover != '0) begin
         col = 0;
         while (col < WORD_BITS - 1 && !leftover[col]) col++;
         for (i = 0; i < WORD_BITS; i++) begin
            if (pivot_copy[i] && basis_copy[i][col]) basis_copy[i] ^= leftover;
         end
         basis_copy[col] = leftover;
         if (!pivot_copy[col]) begin
            pivot_copy[col] = 1'b1;
            if (rank_copy < RANK_MAX) rank_copy++;
         end
         outcome.inserted  = 1'b1;
         outcome.pivot_col = PIVOT_BITS'(col);
      end
      outcome.in_span    = (leftover == '0);
      outcome.residual   = leftover;
      outcome.basis_rank = RANK_BITS'(rank_copy);
      return outcome;
   endfunction

   // offer one word, hold it until accepted, then predict its result
   task automatic send_word(input logic op, input logic [WORD_BITS-1:0] vec);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_vector    <= vec;
      do @(posedge clock); while (req_stall);
      pending_outcomes.insert(pending_outcomes.size(), apply_word(op, vec));
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
   endtask

   task automatic write_coordinates(input logic [COORD_BITS-1:0] value);
      drain_results();
      csr_write              <= 1'b1;
      csr_coordinates_in_use <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      coords_copy = value;
   endtask

   // words mostly built from stored rows so reduction paths get exercised
   function automatic logic [WORD_BITS-1:0] pick_vector();
      logic [WORD_BITS-1:0] vec;
      int unsigned          kind;
      int                   i;
      vec = '0;
      kind = $urandom_range(99);
      for (i = 0; i < WORD_BITS; i++) begin
         if (pivot_copy[i] && $urandom_range(1)) vec ^= basis_copy[i];
      end
      if (kind >= 55 && kind < 80) begin
         vec ^= 64'd1 << $urandom_range(WORD_BITS - 1);
      end else if (kind >= 80 && kind < 92) begin
         vec = {$urandom(), $urandom()};
      end else if (kind >= 92) begin
         vec = (64'd1 << $urandom_range(WORD_BITS - 1)) |
               (64'd1 << $urandom_range(WORD_BITS - 1));
      end
      return vec;
   endfunction

   function automatic logic [COORD_BITS-1:0] pick_coords();
      int unsigned kind;
      kind = $urandom_range(99);
      if (kind < 50) return COORD_BITS'($urandom_range(20, 2));
      if (kind < 80) return COORD_RESET;
      return COORD_BITS'($urandom_range(127));
   endfunction

   // empty basis, extreme words, pivot clearing and repeated inserts
   task automatic test_pivot_cases();
      send_word(OP_REDUCE, '0);
      send_word(OP_INSERT, '0);
      send_word(OP_REDUCE, '1);
      send_word(OP_INSERT, 64'h8000_0000_0000_0000);
      send_word(OP_INSERT, '1);
      send_word(OP_INSERT, 64'h3);
      send_word(OP_INSERT, 64'h3);
      send_word(OP_REDUCE, 64'h5);
      send_word(OP_REDUCE, 64'hAAAA_AAAA_AAAA_AAAA);
   endtask

   // zero count, saturated count and a lowered count with rows stored
   task automatic test_coordinate_limits();
      write_coordinates('0);
      send_word(OP_INSERT, '1);
      send_word(OP_INSERT, 64'h2);
      write_coordinates(7'd5);
      send_word(OP_REDUCE, '1);
      send_word(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFF0);
      send_word(OP_INSERT, 64'h8);
      write_coordinates('1);
      send_word(OP_INSERT, 64'h8000_0000_0000_0100);
      send_word(OP_REDUCE, '1);
      write_coordinates(7'd1);
      send_word(OP_REDUCE, 64'h3);
      write_coordinates(COORD_RESET);
      send_word(OP_INSERT, 64'h5555_5555_5555_5555);
      send_word(OP_REDUCE, '0);
   endtask

   task automatic test_random_traffic(input int unsigned s_idle, input int unsigned r_idle,
                                      input int unsigned segments);
      int unsigned seg;
      int unsigned n;
      send_idle_pct = s_idle;
      recv_idle_pct = r_idle;
      for (seg = 0; seg < segments; seg++) begin
         write_coordinates(pick_coords());
         for (n = 0; n < SEGMENT_SIZE; n++) begin
            send_word(($urandom_range(99) < 60) ? OP_INSERT : OP_REDUCE, pick_vector());
         end
      end
   endtask

   // receiver holds off while words keep coming, so the input must stall
   task automatic test_backlog();
      int unsigned n;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      drain_results();
      backlog_ask++;
      for (n = 0; n < 12; n++) begin
         send_word(($urandom_range(1) != 0) ? OP_INSERT : OP_REDUCE, pick_vector());
      end
   endtask

   // result side: stall pattern, hold-off and field compare
   initial begin
      basis_outcome_type due;
      int unsigned       hold_left;
      int unsigned       backlog_seen;
      hold_left    = 0;
      backlog_seen = 0;
      fail_count   = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (pending_outcomes.size() == 0) begin
               $error("result word with no expectation pending");
               fail_count++;
            end else begin
               due = pending_outcomes.pop_front();
               if (rsp_inserted !== due.inserted) begin
                  $error("inserted: expected %0d, actual %0d", due.inserted, rsp_inserted);
                  fail_count++;
               end
               if (rsp_in_span !== due.in_span) begin
                  $error("in_span: expected %0d, actual %0d", due.in_span, rsp_in_span);
                  fail_count++;
               end
               if (rsp_residual !== due.residual) begin
                  $error("residual: expected %h, actual %h", due.residual, rsp_residual);
                  fail_count++;
               end
               if (rsp_pivot_col !== due.pivot_col) begin
                  $error("pivot_col: expected %0d, actual %0d", due.pivot_col, rsp_pivot_col);
                  fail_count++;
               end
               if (rsp_basis_rank !== due.basis_rank) begin
                  $error("basis_rank: expected %0d, actual %0d",
                         due.basis_rank, rsp_basis_rank);
                  fail_count++;
               end
            end
         end
         if (backlog_ask != backlog_seen) begin
            backlog_seen = backlog_ask;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   // run limit
   initial begin
      #4_000_000;
      $display("status: fail");
      $finish;
   end

   initial begin
      int i;
      for (i = 0; i < WORD_BITS; i++) basis_copy[i] = '0;
      pivot_copy    = '0;
      rank_copy     = 0;
      coords_copy   = COORD_RESET;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      backlog_ask   = 0;
      reset                  <= 1'b1;
      req_valid              <= 1'b0;
      req_operation          <= OP_INSERT;
      req_vector             <= '0;
      csr_write              <= 1'b0;
      csr_coordinates_in_use <= COORD_RESET;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_pivot_cases();
      test_coordinate_limits();
      test_random_traffic(38, 69, 5);
      test_random_traffic(69, 38, 5);
      test_backlog();
      test_random_traffic(0, 0, 5);

      drain_results();
      repeat (WORD_BITS + 8) @(posedge clock);
      if (fail_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule
